// ===== hdl/mi3_pkg.sv =====
package mi3_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MUL_WIDTH  = 2 * DATA_WIDTH;
   localparam int COF_WIDTH  = MUL_WIDTH + 1;
   localparam int DET_WIDTH  = COF_WIDTH + DATA_WIDTH + 2;
   localparam int NUM_WIDTH  = COF_WIDTH + 2 * FRAC_BITS;
   localparam int QUO_STEPS  = NUM_WIDTH;
   localparam int ELEM_COUNT = 9;
   localparam int IDX_WIDTH  = 4;

   localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef logic signed [COF_WIDTH-1:0]  cof_type;
   typedef logic signed [DET_WIDTH-1:0]  det_type;

   typedef struct packed {
      elem_type a00, a01, a02, a10, a11, a12, a20, a21, a22;
   } mat_type;

   typedef struct packed {
      elem_type   inv_value;
      logic [1:0] out_row;
      logic [1:0] out_col;
      logic       is_last;
      logic       singular;
      elem_type   det_value;
   } rsp_type;

   // Saturate a signed magnitude to DATA_WIDTH bits.
   function automatic logic [DATA_WIDTH-1:0] sat_mag(input logic [NUM_WIDTH-1:0] mag,
                                                     input logic neg);
      logic big;
      big = |mag[NUM_WIDTH-1:DATA_WIDTH-1];
      if (!neg) begin
         sat_mag = big ? SAT_MAX : mag[DATA_WIDTH-1:0];
      end else if (big && (mag[DATA_WIDTH-2:0] != '0 ||
                           |mag[NUM_WIDTH-1:DATA_WIDTH])) begin
         sat_mag = SAT_MIN;
      end else begin
         sat_mag = DATA_WIDTH'(-mag[DATA_WIDTH-1:0]);
      end
   endfunction

endpackage

// ===== hdl/mi3_if.sv =====
interface mi3_req_if import mi3_pkg::*; ();
   logic    valid;
   logic    ready;
   mat_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mi3_rsp_if import mi3_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/matrix3x3_inverse.sv =====
// Pipeline: mi3_adj computes the determinant, then 97 divider stages and an
//   output register; elements leave one per cycle unless the output stalls.
// Throughput: the nine-element serializer feeds a single pipelined divider that
//   takes one quotient per cycle unless stalled; a new matrix waits for all nine.
// Reset: synchronous, active high; clears all valid bits and the element counter.
module matrix3x3_inverse import mi3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mi3_req_if.sink     req,
   mi3_rsp_if.source   rsp
);
   logic    adj_valid, adj_ready;
   cof_type adj [ELEM_COUNT];
   det_type det;
   logic    div_ready;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic [1:0] row, col;
   cof_type cur;
   logic [COF_WIDTH-1:0] cmag;
   logic [DET_WIDTH-1:0] dmag;
   logic [DET_WIDTH-1:0] dsh;
   logic    sing, last;
   rsp_type tag;

   mi3_adj u_adj (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_mat (req.data),
      .out_valid (adj_valid), .out_ready (adj_ready),
      .out_adj (adj), .out_det (det)
   );

   always_comb begin
      row  = 2'((32'(idx_ff) * 11) >> 5);
      col  = 2'(idx_ff - 4'(row) * 4'd3);
      cur  = adj[idx_ff];
      cmag = cur[COF_WIDTH-1] ? COF_WIDTH'(-cur) : cur;
      dmag = det[DET_WIDTH-1] ? DET_WIDTH'(-det) : det;
      dsh  = dmag >> (2 * FRAC_BITS);
      sing = (det == '0);
      last = (idx_ff == IDX_WIDTH'(ELEM_COUNT - 1));
      tag.inv_value = '0;
      tag.out_row   = row;
      tag.out_col   = col;
      tag.is_last   = last;
      tag.singular  = sing;
      tag.det_value = sing ? '0 : sat_mag(NUM_WIDTH'(dsh),
                                          det[DET_WIDTH-1] && dsh != '0);
      adj_ready = div_ready && last;
      idx_in    = idx_ff;
      if (adj_valid && div_ready) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   mi3_div u_div (
      .clock, .reset,
      .in_valid (adj_valid), .in_ready (div_ready),
      .in_num ({cmag, {(2*FRAC_BITS){1'b0}}}),
      .in_den (sing ? DET_WIDTH'(1) : dmag),
      .in_tag (tag),
      .in_neg (cur[COF_WIDTH-1] != det[DET_WIDTH-1]),
      .out_valid (rsp.valid), .out_ready (rsp.ready),
      .out_rsp (rsp.data)
   );

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < IDX_WIDTH'(ELEM_COUNT)) else $error("element index out of range");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.singular |-> rsp.data.inv_value == '0 &&
      rsp.data.det_value == '0) else $error("singular result not zero");
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.is_last |-> rsp.data.out_row == 2'd2 &&
      rsp.data.out_col == 2'd2) else $error("last flag misplaced");
endmodule

// ===== hdl/mi3_adj.sv =====
// Four-stage pipeline: products, cofactors, determinant partial products, determinant sum.
module mi3_adj import mi3_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  mat_type   in_mat,
   output logic      out_valid,
   input  logic      out_ready,
   output cof_type   out_adj [ELEM_COUNT],
   output det_type   out_det
);
   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [MUL_WIDTH-1:0] p_ff [18];
   logic signed [MUL_WIDTH-1:0] p_in [18];
   elem_type a0_ff [3], a0b_ff [3];
   cof_type c_ff [ELEM_COUNT], c3_ff [ELEM_COUNT], c4_ff [ELEM_COUNT];
   logic signed [2*DATA_WIDTH:0] tl_ff [3];
   logic signed [2*DATA_WIDTH:0] th_ff [3];
   det_type d_ff;
   logic adv;

   assign adv      = !v4_ff || out_ready;
   assign in_ready = adv;
   assign out_valid = v4_ff;
   assign out_adj  = c4_ff;
   assign out_det  = d_ff;

   always_comb begin
      p_in[0]  = in_mat.a11 * in_mat.a22;  p_in[1]  = in_mat.a21 * in_mat.a12;
      p_in[2]  = in_mat.a02 * in_mat.a21;  p_in[3]  = in_mat.a22 * in_mat.a01;
      p_in[4]  = in_mat.a01 * in_mat.a12;  p_in[5]  = in_mat.a11 * in_mat.a02;
      p_in[6]  = in_mat.a12 * in_mat.a20;  p_in[7]  = in_mat.a22 * in_mat.a10;
      p_in[8]  = in_mat.a00 * in_mat.a22;  p_in[9]  = in_mat.a20 * in_mat.a02;
      p_in[10] = in_mat.a02 * in_mat.a10;  p_in[11] = in_mat.a12 * in_mat.a00;
      p_in[12] = in_mat.a10 * in_mat.a21;  p_in[13] = in_mat.a20 * in_mat.a11;
      p_in[14] = in_mat.a01 * in_mat.a20;  p_in[15] = in_mat.a21 * in_mat.a00;
      p_in[16] = in_mat.a00 * in_mat.a11;  p_in[17] = in_mat.a10 * in_mat.a01;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff  <= p_in;
         a0_ff <= '{in_mat.a00, in_mat.a01, in_mat.a02};
         for (int i = 0; i < ELEM_COUNT; i++) begin
            c_ff[i] <= COF_WIDTH'(p_ff[2*i]) - COF_WIDTH'(p_ff[2*i+1]);
         end
         a0b_ff <= a0_ff;
         c3_ff  <= c_ff;
         // Split each first-row cofactor into a low unsigned and a high signed half.
         for (int k = 0; k < 3; k++) begin
            tl_ff[k] <= a0b_ff[k] * $signed({1'b0, c_ff[3*k][DATA_WIDTH-1:0]});
            th_ff[k] <= a0b_ff[k] * $signed(c_ff[3*k][COF_WIDTH-1:DATA_WIDTH]);
         end
         c4_ff <= c3_ff;
         d_ff  <= (DET_WIDTH'(th_ff[0]) <<< DATA_WIDTH) + DET_WIDTH'(tl_ff[0]) +
                  (DET_WIDTH'(th_ff[1]) <<< DATA_WIDTH) + DET_WIDTH'(tl_ff[1]) +
                  (DET_WIDTH'(th_ff[2]) <<< DATA_WIDTH) + DET_WIDTH'(tl_ff[2]);
      end
   end
endmodule

// ===== hdl/mi3_div.sv =====
// Radix-2 restoring divider pipeline, one quotient bit per stage, unsigned.
module mi3_div import mi3_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [NUM_WIDTH-1:0] in_num,
   input  logic [DET_WIDTH-1:0] in_den,
   input  rsp_type              in_tag,
   input  logic                 in_neg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rsp_type              out_rsp
);
   logic                 v_ff   [QUO_STEPS+1];
   logic [NUM_WIDTH-1:0] q_ff   [QUO_STEPS+1];
   logic [DET_WIDTH:0]   r_ff   [QUO_STEPS+1];
   logic [DET_WIDTH-1:0] d_ff   [QUO_STEPS+1];
   rsp_type              t_ff   [QUO_STEPS+1];
   logic                 n_ff   [QUO_STEPS+1];
   rsp_type              o_ff;
   rsp_type              o_in;
   logic                 ov_ff;
   logic                 adv;

   assign adv       = !ov_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = ov_ff;
   assign out_rsp   = o_ff;

   always_comb begin
      v_ff[0] = in_valid; q_ff[0] = in_num; r_ff[0] = '0;
      d_ff[0] = in_den;   t_ff[0] = in_tag; n_ff[0] = in_neg;
   end

   for (genvar s = 0; s < QUO_STEPS; s++) begin : g_step
      logic [DET_WIDTH:0] sh;
      logic [DET_WIDTH:0] df;
      assign sh = {r_ff[s][DET_WIDTH-1:0], q_ff[s][NUM_WIDTH-1]};
      assign df = sh - {1'b0, d_ff[s]};
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (adv) begin
            v_ff[s+1] <= v_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[s+1] <= df[DET_WIDTH] ? sh : df;
            q_ff[s+1] <= {q_ff[s][NUM_WIDTH-2:0], ~df[DET_WIDTH]};
            d_ff[s+1] <= d_ff[s];
            t_ff[s+1] <= t_ff[s];
            n_ff[s+1] <= n_ff[s];
         end
      end
   end

   always_comb begin
      o_in = t_ff[QUO_STEPS];
      if (t_ff[QUO_STEPS].singular) begin
         o_in.inv_value = '0;
      end else begin
         o_in.inv_value = sat_mag(q_ff[QUO_STEPS],
                                  n_ff[QUO_STEPS] && q_ff[QUO_STEPS] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= v_ff[QUO_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_ff <= o_in;
      end
   end
endmodule
